[rtl/hsv_to_rgb_macros.svh]
// Assertion macros shared by the HSV to RGB converter RTL.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef HSV_TO_RGB_MACROS_SVH
`define HSV_TO_RGB_MACROS_SVH

// Property that must hold in the same cycle as its condition.
`define HSV_ASSERT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Property that must hold in the cycle after its condition.
`define HSV_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

[rtl/hsv2rgb_pkg.sv]
// Package for the HSV to RGB converter: hue constants, sector codes, helpers.
// Depends on nothing; imported by hsv_to_rgb.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  // Default channel width for saturation, value and the color outputs.
  localparam int ChannelBitsDefault = 8;

  // Hue is degrees times 64.
  localparam int HueBits   = 15;
  localparam int HueFull   = 23040;
  localparam int HueSector = 3840;
  localparam int RemBits   = 12;

  // Fraction within a sector, 0.12 format.
  localparam int FracBits = 12;

  // floor(x / 15) = (x * Recip15) >> RecipShift for x below 3840.
  localparam int RecipBits  = 13;
  localparam int Recip15    = 4370;
  localparam int RecipShift = 16;

  // Places of p, q and t in the per-channel arrays.
  localparam int IdxP   = 0;
  localparam int IdxQ   = 1;
  localparam int IdxT   = 2;
  localparam int NumFac = 3;

  // Hue sectors of 60 degrees each.
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_e;

  // First hue code of a sector.
  function automatic logic [HueBits-1:0] sector_base(sector_e sec);
    logic [HueBits-1:0] base;
    unique case (sec)
      SEC_RY:  base = HueBits'(0);
      SEC_YG:  base = HueBits'(HueSector);
      SEC_GC:  base = HueBits'(2 * HueSector);
      SEC_CB:  base = HueBits'(3 * HueSector);
      SEC_BM:  base = HueBits'(4 * HueSector);
      SEC_MR:  base = HueBits'(5 * HueSector);
      default: base = HueBits'(0);
    endcase
    return base;
  endfunction

endpackage

[rtl/hsv_to_rgb.sv]
// HSV to RGB converter, six-stage pipeline, one pixel per clock unless stalled.
// Each stage advances while its successor has room, so bubbles are squeezed out.
// Reset (rst_ni low, asynchronous) empties the pipeline; no data is cleared.
// Depends on hsv2rgb_pkg and hsv_to_rgb_macros.svh.
`timescale 1ns / 1ps

`include "hsv_to_rgb_macros.svh"

module hsv_to_rgb
  import hsv2rgb_pkg::*;
#(
  parameter int ChannelBits = ChannelBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [HueBits-1:0]     hue_i,
  input  logic [ChannelBits-1:0] saturation_i,
  input  logic [ChannelBits-1:0] brightness_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [ChannelBits-1:0] red_o,
  output logic [ChannelBits-1:0] green_o,
  output logic [ChannelBits-1:0] blue_o
);

  localparam int FactW = ChannelBits + FracBits;
  localparam int ProdW = ChannelBits + FactW;
  localparam int DivW  = 2 * ChannelBits;
  localparam int MulW  = RemBits + RecipBits;

  localparam logic [ChannelBits-1:0] ChanMax = {ChannelBits{1'b1}};
  localparam logic [FactW-1:0]       FullScale = {ChanMax, {FracBits{1'b0}}};
  localparam logic [ProdW:0]         RoundHalf = (ProdW + 1)'(FullScale) >> 1;

  // Stage valid bits and the ready chain from the output backwards.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6 = !v6_q || !out_stall_i;
  assign rdy5 = !v5_q || rdy6;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
    end
  end

  // Stage 1: hue at or above full circle becomes 0; find its sector and remainder.
  logic [HueBits-1:0]     hue_wrap;
  sector_e                sec1_d;
  logic [HueBits-1:0]     rem_full;
  sector_e                sec1_q;
  logic [RemBits-1:0]     rem1_q;
  logic [ChannelBits-1:0] sat1_q, bri1_q;

  always_comb begin
    hue_wrap = (hue_i >= HueBits'(HueFull)) ? '0 : hue_i;
    if (hue_wrap >= HueBits'(5 * HueSector)) begin
      sec1_d = SEC_MR;
    end else if (hue_wrap >= HueBits'(4 * HueSector)) begin
      sec1_d = SEC_BM;
    end else if (hue_wrap >= HueBits'(3 * HueSector)) begin
      sec1_d = SEC_CB;
    end else if (hue_wrap >= HueBits'(2 * HueSector)) begin
      sec1_d = SEC_GC;
    end else if (hue_wrap >= HueBits'(HueSector)) begin
      sec1_d = SEC_YG;
    end else begin
      sec1_d = SEC_RY;
    end
    rem_full = hue_wrap - sector_base(sec1_d);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      sec1_q <= sec1_d;
      rem1_q <= rem_full[RemBits-1:0];
      sat1_q <= saturation_i;
      bri1_q <= brightness_i;
    end
  end

  // Stage 2: fraction f = floor(rem * 16 / 15) = rem + floor(rem / 15).
  logic [MulW-1:0]        rem_mul;
  logic [FracBits-1:0]    frac2_d;
  sector_e                sec2_q;
  logic [FracBits-1:0]    frac2_q;
  logic [ChannelBits-1:0] sat2_q, bri2_q;

  always_comb begin
    rem_mul = MulW'(rem1_q) * MulW'(Recip15);
    frac2_d = FracBits'(rem1_q) + FracBits'(rem_mul >> RecipShift);
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      sec2_q  <= sec1_q;
      frac2_q <= frac2_d;
      sat2_q  <= sat1_q;
      bri2_q  <= bri1_q;
    end
  end

  // Stage 3: scale factors for p, q and t, each against full scale M * 4096.
  logic [FactW-1:0]              sf;
  logic [ChannelBits-1:0]        sat_inv;
  logic [NumFac-1:0][FactW-1:0]  fac3_d;
  sector_e                       sec3_q;
  logic [NumFac-1:0][FactW-1:0]  fac3_q;
  logic [ChannelBits-1:0]        bri3_q;

  always_comb begin
    sf            = FactW'(sat2_q) * FactW'(frac2_q);
    sat_inv       = ChanMax - sat2_q;
    fac3_d[IdxP]  = {sat_inv, {FracBits{1'b0}}};
    fac3_d[IdxQ]  = FullScale - sf;
    fac3_d[IdxT]  = fac3_d[IdxP] + sf;
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      sec3_q <= sec2_q;
      fac3_q <= fac3_d;
      bri3_q <= bri2_q;
    end
  end

  // Stage 4: multiply each factor by the value.
  logic [NumFac-1:0][ProdW-1:0] prod4_d;
  sector_e                      sec4_q;
  logic [NumFac-1:0][ProdW-1:0] prod4_q;
  logic [ChannelBits-1:0]       bri4_q;

  always_comb begin
    for (int i = 0; i < NumFac; i++) begin
      prod4_d[i] = ProdW'(fac3_q[i]) * ProdW'(bri3_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      sec4_q  <= sec3_q;
      prod4_q <= prod4_d;
      bri4_q  <= bri3_q;
    end
  end

  // Stage 5: round and divide by M * 4096: shift out 4096, then divide by
  // M = 2^C - 1 with (y + 1 + (y >> C)) >> C.
  logic [NumFac-1:0][ProdW:0]         rnd;
  logic [NumFac-1:0][DivW-1:0]        ydiv;
  logic [NumFac-1:0][DivW:0]          zdiv;
  logic [NumFac-1:0][ChannelBits-1:0] chan5_d;
  sector_e                            sec5_q;
  logic [NumFac-1:0][ChannelBits-1:0] chan5_q;
  logic [ChannelBits-1:0]             bri5_q;

  always_comb begin
    for (int i = 0; i < NumFac; i++) begin
      rnd[i]     = (ProdW + 1)'(prod4_q[i]) + RoundHalf;
      ydiv[i]    = DivW'(rnd[i] >> FracBits);
      zdiv[i]    = (DivW + 1)'(ydiv[i]) + (DivW + 1)'(1)
                 + (DivW + 1)'(ydiv[i] >> ChannelBits);
      chan5_d[i] = ChannelBits'(zdiv[i] >> ChannelBits);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      sec5_q  <= sec4_q;
      chan5_q <= chan5_d;
      bri5_q  <= bri4_q;
    end
  end

  // Stage 6: pick the output triple by sector. Zero saturation makes
  // p, q and t all equal the value, which yields grey.
  logic [ChannelBits-1:0] red_d, green_d, blue_d;
  logic [ChannelBits-1:0] red_q, green_q, blue_q, bri6_q;

  always_comb begin
    unique case (sec5_q)
      SEC_RY: begin
        red_d = bri5_q;        green_d = chan5_q[IdxT]; blue_d = chan5_q[IdxP];
      end
      SEC_YG: begin
        red_d = chan5_q[IdxQ]; green_d = bri5_q;        blue_d = chan5_q[IdxP];
      end
      SEC_GC: begin
        red_d = chan5_q[IdxP]; green_d = bri5_q;        blue_d = chan5_q[IdxT];
      end
      SEC_CB: begin
        red_d = chan5_q[IdxP]; green_d = chan5_q[IdxQ]; blue_d = bri5_q;
      end
      SEC_BM: begin
        red_d = chan5_q[IdxT]; green_d = chan5_q[IdxP]; blue_d = bri5_q;
      end
      default: begin
        red_d = bri5_q;        green_d = chan5_q[IdxP]; blue_d = chan5_q[IdxQ];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy6) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      bri6_q  <= bri5_q;
    end
  end

  assign out_valid_o = v6_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  // An accepted transaction always lands in the first stage.
  `HSV_ASSERT_NEXT(a_accept_fills_s1, in_valid_i && !in_stall_o, v1_q,
    "accepted transaction did not enter stage 1")

  // No channel may exceed the value of its pixel.
  `HSV_ASSERT(a_chan_le_value, out_valid_o,
    red_o <= bri6_q && green_o <= bri6_q && blue_o <= bri6_q,
    "output channel exceeds brightness")

  // The largest channel always equals the value.
  `HSV_ASSERT(a_max_is_value, out_valid_o,
    red_o == bri6_q || green_o == bri6_q || blue_o == bri6_q,
    "no output channel equals brightness")

endmodule
